// File: rtl/core/greedy_box_suppression_macros.svh
// ----------------------------------------------------------------------------
// greedy box suppression assertion macros
// shared concurrent assertion forms, clocked on clk and gated by rst_n
// ----------------------------------------------------------------------------
`ifndef GREEDY_BOX_SUPPRESSION_MACROS_SVH
`define GREEDY_BOX_SUPPRESSION_MACROS_SVH

// same-cycle implication
`define GBS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define GBS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/gbs_pkg.sv
// ----------------------------------------------------------------------------
// gbs_pkg
// widths, box and request types shared by the suppression block
// ----------------------------------------------------------------------------
package gbs_pkg;

  localparam int MAX_KEPT    = 64;
  localparam int COORD_BITS  = 12;
  localparam int DIM_W       = COORD_BITS - 1;
  localparam int AREA_W      = 2 * DIM_W;
  localparam int THR_W       = 9;
  localparam int THR_FRAC    = 8;
  localparam int CNT_W       = $clog2(MAX_KEPT + 1);
  localparam int IDX_W       = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(128);

  typedef struct packed {
    logic signed [COORD_BITS-1:0] left;
    logic signed [COORD_BITS-1:0] top;
    logic [DIM_W-1:0]             width;
    logic [DIM_W-1:0]             height;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  // request handed from the front end to the compare engine
  typedef struct packed {
    box_t              box;
    logic              start;
    logic [AREA_W-1:0] area;
  } cmd_t;

endpackage

// File: rtl/core/gbs_front.sv
// ----------------------------------------------------------------------------
// gbs_front
// input stage: takes a box request, works out its area, feeds the queue
// ----------------------------------------------------------------------------
module gbs_front (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [gbs_pkg::COORD_BITS-1:0] in_box_left,
  input  logic signed [gbs_pkg::COORD_BITS-1:0] in_box_top,
  input  logic [gbs_pkg::DIM_W-1:0]             in_box_width,
  input  logic [gbs_pkg::DIM_W-1:0]             in_box_height,
  input  logic                                  in_start_frame,
  input  logic                                  q_full,
  output logic                                  q_push,
  output gbs_pkg::cmd_t                         q_cmd
);
  import gbs_pkg::*;

  logic valid_r, valid_nxt;
  box_t box_r;
  logic start_r;
  logic accept;

  assign full   = valid_r && q_full;
  assign accept = push && !full;
  assign valid_nxt = accept || (valid_r && q_full);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      box_r.left   <= in_box_left;
      box_r.top    <= in_box_top;
      box_r.width  <= in_box_width;
      box_r.height <= in_box_height;
      start_r      <= in_start_frame;
    end
  end

  // own area is needed for every comparison, so do it once here
  always_comb begin
    q_cmd.box   = box_r;
    q_cmd.start = start_r;
    q_cmd.area  = AREA_W'(box_r.width * box_r.height);
  end

  assign q_push = valid_r;

endmodule

// File: rtl/core/gbs_fifo.sv
// ----------------------------------------------------------------------------
// gbs_fifo
// short request queue between the front end and the compare engine
// ----------------------------------------------------------------------------
module gbs_fifo (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  gbs_pkg::cmd_t wr_data,
  output logic          full,
  input  logic          rd_en,
  output gbs_pkg::cmd_t rd_data,
  output logic          empty
);
  import gbs_pkg::*;

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              do_wr, do_rd;

  assign full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];

endmodule

// File: rtl/core/gbs_back.sv
// ----------------------------------------------------------------------------
// gbs_back
// compare engine: scans the picked list through one iou pipeline, updates it
// ----------------------------------------------------------------------------
module gbs_back (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_empty,
  input  gbs_pkg::cmd_t            q_cmd,
  output logic                     q_pop,
  input  logic [gbs_pkg::THR_W-1:0] thr,
  output logic                     empty,
  input  logic                     pop,
  output logic                     out_keep,
  output logic                     out_store_full
);
  import gbs_pkg::*;
  `include "greedy_box_suppression_macros.svh"

  localparam int EXT_W  = COORD_BITS + 2;
  localparam int UNI_W  = AREA_W + 1;
  localparam int PROD_W = THR_W + UNI_W;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  function automatic logic [DIM_W-1:0] overlap(
    input logic signed [COORD_BITS-1:0] a0,
    input logic [DIM_W-1:0]             al,
    input logic signed [COORD_BITS-1:0] b0,
    input logic [DIM_W-1:0]             bl
  );
    logic signed [EXT_W-1:0] as, ae, bs, be, lo, hi, d;
    as = {{2{a0[COORD_BITS-1]}}, a0};
    bs = {{2{b0[COORD_BITS-1]}}, b0};
    ae = as + $signed({3'b000, al});
    be = bs + $signed({3'b000, bl});
    lo = (as > bs) ? as : bs;
    hi = (ae < be) ? ae : be;
    d  = hi - lo;
    return (hi > lo) ? d[DIM_W-1:0] : '0;
  endfunction

  state_t            st_r, st_nxt;
  box_t              cur_r;
  logic [AREA_W-1:0] cur_area_r;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;
  logic              supp_r, supp_nxt;
  logic              res_valid_r, res_valid_nxt;
  logic              res_keep_r, res_full_r;

  logic [BOX_W-1:0]  list_mem [MAX_KEPT];
  box_t              rd_data_r;
  logic              rd_en, wr_en, finish, pipe_empty, load, res_keep, res_full;

  // compare pipeline
  logic              v1_r, v2_r, v3_r, v4_r;
  logic [DIM_W-1:0]  ow_r, oh_r, bw_r, bh_r;
  logic [AREA_W-1:0] inter_r, area_b_r, inter4_r;
  logic [UNI_W-1:0]  uni_r;
  logic [PROD_W-1:0] prod, lhs;

  assign pipe_empty = !(v1_r || v2_r || v3_r || v4_r);
  assign load       = (st_r == ST_IDLE) && !q_empty;
  assign q_pop      = load;
  assign rd_en      = (st_r == ST_SCAN) && (idx_r < count_r);
  assign finish     = (st_r == ST_DRAIN) && pipe_empty && (!res_valid_r || pop);
  assign res_keep   = !supp_r;
  assign res_full   = res_keep && (count_r == CNT_W'(MAX_KEPT));
  assign wr_en      = finish && res_keep && !res_full;

  assign prod = PROD_W'(thr * uni_r);
  assign lhs  = PROD_W'({inter4_r, {THR_FRAC{1'b0}}});

  always_comb begin
    st_nxt    = st_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    supp_nxt  = supp_r || (v4_r && (lhs > prod));
    unique case (st_r)
      ST_IDLE: begin
        if (load) begin
          count_nxt = q_cmd.start ? '0 : count_r;
          idx_nxt   = '0;
          supp_nxt  = 1'b0;
          st_nxt    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_en) begin
          idx_nxt = idx_r + 1'b1;
        end else begin
          st_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (finish) begin
          st_nxt = ST_IDLE;
          if (wr_en) begin
            count_nxt = count_r + 1'b1;
          end
        end
      end
      default: begin
        st_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_valid_nxt = res_valid_r;
    if (finish) begin
      res_valid_nxt = 1'b1;
    end else if (pop && res_valid_r) begin
      res_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      count_r     <= '0;
      idx_r       <= '0;
      supp_r      <= 1'b0;
      res_valid_r <= 1'b0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      supp_r      <= supp_nxt;
      res_valid_r <= res_valid_nxt;
      v1_r        <= rd_en;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cur_r      <= q_cmd.box;
      cur_area_r <= q_cmd.area;
    end
    if (finish) begin
      res_keep_r <= res_keep;
      res_full_r <= res_full;
    end
  end

  // picked list
  always_ff @(posedge clk) begin
    if (wr_en) begin
      list_mem[count_r[IDX_W-1:0]] <= cur_r;
    end
    if (rd_en) begin
      rd_data_r <= list_mem[idx_r[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    ow_r     <= overlap(cur_r.left, cur_r.width, rd_data_r.left, rd_data_r.width);
    oh_r     <= overlap(cur_r.top, cur_r.height, rd_data_r.top, rd_data_r.height);
    bw_r     <= rd_data_r.width;
    bh_r     <= rd_data_r.height;
    inter_r  <= AREA_W'(ow_r * oh_r);
    area_b_r <= AREA_W'(bw_r * bh_r);
    inter4_r <= inter_r;
    uni_r    <= UNI_W'(cur_area_r) + UNI_W'(area_b_r) - UNI_W'(inter_r);
  end

  assign empty          = !res_valid_r;
  assign out_keep       = res_keep_r;
  assign out_store_full = res_full_r;

  `GBS_ASSERT_NOW(a_count_bound, 1'b1, count_r <= CNT_W'(MAX_KEPT), "picked count overflow")
  `GBS_ASSERT_NOW(a_read_in_range, rd_en, (st_r == ST_SCAN) && (idx_r < count_r), "bad list read")
  `GBS_ASSERT_NOW(a_finish_drained, finish, pipe_empty && !rd_en, "result before pipeline drained")
  `GBS_ASSERT_NOW(a_full_needs_keep, res_valid_r && res_full_r, res_keep_r, "full flag without keep")
  `GBS_ASSERT_NEXT(a_finish_idle, finish, (st_r == ST_IDLE) && res_valid_r, "finish did not retire")

endmodule

// File: rtl/core/greedy_box_suppression.sv
// ----------------------------------------------------------------------------
// greedy_box_suppression
// greedy iou-based box suppression over a list of picked boxes
// ----------------------------------------------------------------------------
// Boxes go in through a queue-style port (push/full) in descending confidence
// order; each gives one keep/store_full result on the result port
// (empty/pop). A request stays in the compare engine for the scan of the
// picked list, plus any wait for the previous result to be popped: the
// picked-list memory is read one entry per cycle into a single iou compare
// pipeline, and the list update waits for that pipeline to drain. Two queued
// requests and the input register let the next boxes be taken while one is
// judged. No clearing pass is needed after reset. The user must write the
// threshold on the cfg port only while idle; the block does not enforce it.
module greedy_box_suppression (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  push,
  output logic                                  full,
  input  logic signed [gbs_pkg::COORD_BITS-1:0] in_box_left,
  input  logic signed [gbs_pkg::COORD_BITS-1:0] in_box_top,
  input  logic [gbs_pkg::DIM_W-1:0]             in_box_width,
  input  logic [gbs_pkg::DIM_W-1:0]             in_box_height,
  input  logic                                  in_start_frame,
  output logic                                  empty,
  input  logic                                  pop,
  output logic                                  out_keep,
  output logic                                  out_store_full,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [gbs_pkg::THR_W-1:0]             cfg_data
);
  import gbs_pkg::*;

  logic [THR_W-1:0] thr_r;
  logic             q_push, q_full, q_pop, q_empty;
  cmd_t             q_wr_cmd, q_rd_cmd;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THR_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  gbs_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_box_left    (in_box_left),
    .in_box_top     (in_box_top),
    .in_box_width   (in_box_width),
    .in_box_height  (in_box_height),
    .in_start_frame (in_start_frame),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_wr_cmd)
  );

  gbs_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (q_wr_cmd),
    .full    (q_full),
    .rd_en   (q_pop),
    .rd_data (q_rd_cmd),
    .empty   (q_empty)
  );

  gbs_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_cmd          (q_rd_cmd),
    .q_pop          (q_pop),
    .thr            (thr_r),
    .empty          (empty),
    .pop            (pop),
    .out_keep       (out_keep),
    .out_store_full (out_store_full)
  );

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for greedy_box_suppression: frames of clustered, gridded
// and noisy boxes are pushed under several iou thresholds while both sides
// stall at random, and every keep/store_full result is checked in order
// ----------------------------------------------------------------------------
module tb_top;
  import gbs_pkg::*;

  localparam int COORD_MIN   = -(1 << (COORD_BITS - 1));
  localparam int COORD_MAX   = (1 << (COORD_BITS - 1)) - 1;
  localparam int DIM_MAX     = (1 << DIM_W) - 1;
  localparam int IDLE_LIMIT  = 4000;
  localparam int DRAIN_WAIT  = MAX_KEPT + 16;
  localparam int LONG_HOLD   = 800;
  localparam int PHASE_ITEMS = 160;
  localparam int MAX_PRINTS  = 20;
  localparam int N_PLANS     = 9;

  typedef struct {
    box_t box;
    logic start;
  } box_req_t;

  typedef struct {
    logic keep;
    logic store_full;
  } verdict_t;

  logic                         clk            = 1'b0;
  logic                         rst_n          = 1'b0;
  logic                         push           = 1'b0;
  logic                         full;
  logic signed [COORD_BITS-1:0] in_box_left    = '0;
  logic signed [COORD_BITS-1:0] in_box_top     = '0;
  logic [DIM_W-1:0]             in_box_width   = '0;
  logic [DIM_W-1:0]             in_box_height  = '0;
  logic                         in_start_frame = 1'b0;
  logic                         empty;
  logic                         pop            = 1'b0;
  logic                         out_keep;
  logic                         out_store_full;
  logic                         cfg_valid      = 1'b0;
  logic                         cfg_ready;
  logic [THR_W-1:0]             cfg_data       = '0;

  // predictor state
  box_t             picked_list[MAX_KEPT];
  int               picked_total = 0;
  logic [THR_W-1:0] iou_thr      = THR_RESET;

  box_req_t boxes_to_send[$];
  verdict_t verdicts_due[$];
  box_req_t on_bus;

  bit steady      = 1'b0;
  bit hold_wanted = 1'b0;
  int push_gap    = 0;
  int pop_gap     = 0;
  int hold_left   = 0;
  int idle_cycles = 0;

  int mismatch_count = 0;
  int boxes_sent     = 0;
  int results_seen   = 0;
  int kept_seen      = 0;
  int dropped_seen   = 0;
  int overflow_seen  = 0;
  int thr_plan[N_PLANS] = '{0, 256, 511, 1, 64, 200, 255, 128, 0};

  greedy_box_suppression uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (push),
    .full           (full),
    .in_box_left    (in_box_left),
    .in_box_top     (in_box_top),
    .in_box_width   (in_box_width),
    .in_box_height  (in_box_height),
    .in_start_frame (in_start_frame),
    .empty          (empty),
    .pop            (pop),
    .out_keep       (out_keep),
    .out_store_full (out_store_full),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------- predictor

  function automatic longint span_overlap(longint a0, longint alen, longint b0,
                                          longint blen);
    longint lo, hi;
    lo = (a0 > b0) ? a0 : b0;
    hi = (a0 + alen < b0 + blen) ? a0 + alen : b0 + blen;
    return (hi > lo) ? hi - lo : 0;
  endfunction

  function automatic bit iou_above(box_t a, box_t b);
    longint inter, area_a, area_b, uni;
    inter  = span_overlap($signed(a.left), a.width, $signed(b.left), b.width) *
             span_overlap($signed(a.top), a.height, $signed(b.top), b.height);
    area_a = longint'(a.width) * longint'(a.height);
    area_b = longint'(b.width) * longint'(b.height);
    uni    = area_a + area_b - inter;
    return inter * (longint'(1) << THR_FRAC) > longint'(iou_thr) * uni;
  endfunction

  function automatic verdict_t judge_box(box_req_t r);
    verdict_t v;
    if (r.start) picked_total = 0;
    v.keep       = 1'b1;
    v.store_full = 1'b0;
    for (int i = 0; i < picked_total; i++) begin
      if (iou_above(r.box, picked_list[i])) v.keep = 1'b0;
    end
    if (v.keep) begin
      if (picked_total < MAX_KEPT) begin
        picked_list[picked_total] = r.box;
        picked_total++;
      end else begin
        v.store_full = 1'b1;
      end
    end
    return v;
  endfunction

  // ---------------------------------------------------------------- helpers

  function automatic int rand_between(int lo, int hi);
    return lo + int'($urandom_range(0, hi - lo));
  endfunction

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  // mostly short gaps, now and then a long one, none in steady stretches
  function automatic int gap_len();
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic queue_box(int l, int t, int w, int h, bit s);
    box_req_t r;
    r.box.left   = COORD_BITS'(clamp(l, COORD_MIN, COORD_MAX));
    r.box.top    = COORD_BITS'(clamp(t, COORD_MIN, COORD_MAX));
    r.box.width  = DIM_W'(clamp(w, 0, DIM_MAX));
    r.box.height = DIM_W'(clamp(h, 0, DIM_MAX));
    r.start      = s;
    boxes_to_send = {boxes_to_send, r};
  endtask

  // detections piled around a few objects, as a real frame would give
  task automatic add_cluster_frame(int n, bit loose_starts);
    int cx[4], cy[4], cw[4], ch[4];
    int k, c, jx, jy, j;
    bit s;
    k = $urandom_range(1, 4);
    for (j = 0; j < k; j++) begin
      cx[j] = rand_between(-1800, 1800);
      cy[j] = rand_between(-1800, 1800);
      cw[j] = ($urandom_range(0, 9) == 0) ? rand_between(1000, DIM_MAX) : rand_between(0, 300);
      ch[j] = ($urandom_range(0, 9) == 0) ? rand_between(1000, DIM_MAX) : rand_between(0, 300);
    end
    for (j = 0; j < n; j++) begin
      c  = $urandom_range(0, k - 1);
      jx = cw[c] / 4 + 1;
      jy = ch[c] / 4 + 1;
      s  = (j == 0) ? 1'b1 : (loose_starts && $urandom_range(0, 7) == 0);
      queue_box(cx[c] + rand_between(-jx, jx), cy[c] + rand_between(-jy, jy),
                cw[c] + rand_between(-jx, jx), ch[c] + rand_between(-jy, jy), s);
    end
  endtask

  // disjoint or touching boxes, enough of them to fill the picked list and mostly to overflow it
  task automatic add_grid_frame(int n);
    int j;
    for (j = 0; j < n; j++) begin
      queue_box(COORD_MIN + (j % 40) * 50, COORD_MIN + (j / 40) * 50,
                rand_between(0, 50), rand_between(0, 50), j == 0);
    end
  endtask

  task automatic add_noise(int n);
    box_req_t r;
    int j;
    for (j = 0; j < n; j++) begin
      r.box   = BOX_W'({$urandom, $urandom});
      r.start = ($urandom_range(0, 9) == 0);
      boxes_to_send = {boxes_to_send, r};
    end
  endtask

  task automatic add_random_phase(int budget);
    int added, n, pick;
    added = 0;
    while (added < budget) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        n = $urandom_range(4, 30);
        add_cluster_frame(n, 1'b0);
      end else if (pick < 62) begin
        n = $urandom_range(MAX_KEPT, MAX_KEPT + 16);
        add_grid_frame(n);
      end else if (pick < 82) begin
        n = $urandom_range(1, 8);
        add_noise(n);
      end else begin
        n = $urandom_range(4, 30);
        add_cluster_frame(n, 1'b1);
      end
      added += n;
    end
  endtask

  task automatic wait_drained();
    while (boxes_to_send.size() != 0 || push || verdicts_due.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_threshold(int v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= THR_W'(v);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    iou_thr = THR_W'(v);
  endtask

  task automatic report_mismatch(string what, logic got, logic want);
    if (mismatch_count < MAX_PRINTS)
      $display("[%0t] result %0d: %s got %b want %b", $time, results_seen, what, got, want);
    mismatch_count++;
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst_n) begin
      if (push && !full) begin
        verdicts_due = {verdicts_due, judge_box(on_bus)};
        boxes_sent++;
        push_gap = gap_len();
      end
      // a request refused by a full block stays on the bus unchanged
      if (!(push && full)) begin
        if (push_gap > 0) begin
          push_gap--;
          push <= 1'b0;
        end else if (boxes_to_send.size() != 0) begin
          on_bus = boxes_to_send.pop_front();
          in_box_left    <= on_bus.box.left;
          in_box_top     <= on_bus.box.top;
          in_box_width   <= on_bus.box.width;
          in_box_height  <= on_bus.box.height;
          in_start_frame <= on_bus.start;
          push           <= 1'b1;
        end else begin
          push <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin
    verdict_t want;
    if (rst_n) begin
      if (pop && !empty) begin
        if (verdicts_due.size() == 0) begin
          report_mismatch("unexpected result, keep", out_keep, 1'bx);
        end else begin
          want = verdicts_due.pop_front();
          if (out_keep !== want.keep) report_mismatch("keep", out_keep, want.keep);
          if (out_store_full !== want.store_full)
            report_mismatch("store_full", out_store_full, want.store_full);
          if (want.store_full) overflow_seen++;
          else if (want.keep) kept_seen++;
          else dropped_seen++;
        end
        results_seen++;
        pop_gap = gap_len();
      end
      if (hold_wanted) begin
        hold_left   = LONG_HOLD;
        hold_wanted = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------- watchdog

  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout: no request moved for %0d cycles", IDLE_LIMIT);
      $display("end of test: mismatches");
      $finish;
    end
  end

  // ---------------------------------------------------------------- sequence

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset threshold of one half
    queue_box(0, 0, 10, 10, 1'b1);
    queue_box(0, 0, 10, 10, 1'b0);          // identical, suppressed
    queue_box(10, 0, 10, 10, 1'b0);         // touching edge, no overlap
    queue_box(5, 0, 10, 10, 1'b0);          // iou one third, kept
    queue_box(1, 0, 10, 10, 1'b0);          // heavy overlap, suppressed
    queue_box(500, 500, 0, 0, 1'b0);        // empty box
    queue_box(500, 500, 0, 0, 1'b0);        // two empty boxes, zero union
    queue_box(COORD_MIN, COORD_MIN, DIM_MAX, DIM_MAX, 1'b0);
    queue_box(COORD_MAX, COORD_MAX, DIM_MAX, DIM_MAX, 1'b0);
    queue_box(COORD_MAX, COORD_MAX, DIM_MAX, DIM_MAX, 1'b0);
    queue_box(COORD_MIN, COORD_MIN, DIM_MAX, DIM_MAX, 1'b1);   // new frame clears list
    queue_box(COORD_MIN, COORD_MIN, DIM_MAX, DIM_MAX, 1'b0);
    queue_box(-1, -1, DIM_MAX, DIM_MAX, 1'b0);
    queue_box(-1, COORD_MIN, 1, DIM_MAX, 1'b0);
    queue_box(COORD_MIN, COORD_MAX, DIM_MAX, 0, 1'b0);
    queue_box(0, 0, DIM_MAX, DIM_MAX, 1'b0);
    add_random_phase(PHASE_ITEMS);
    wait_drained();

    thr_plan[N_PLANS-1] = $urandom_range(0, 256);
    for (int p = 0; p < N_PLANS; p++) begin
      set_threshold(thr_plan[p]);
      steady = (p % 3 == 1);
      add_random_phase(PHASE_ITEMS);
      // receiver sits out while requests keep coming, so the block backs up
      if (p == 2) hold_wanted = 1'b1;
      wait_drained();
    end

    $display("covered %0d boxes over %0d threshold settings, clusters, grids and noise",
             boxes_sent, N_PLANS + 1);
    $display("results: %0d kept, %0d suppressed, %0d kept with the list full",
             kept_seen, dropped_seen, overflow_seen);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
